// ----- sv/sump_command_capture_engine_defines.svh -----
// assertion macros shared by the capture engine modules
`ifndef SUMP_COMMAND_CAPTURE_ENGINE_DEFINES_SVH
`define SUMP_COMMAND_CAPTURE_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sce assertion failed");
// next-cycle implication
`define SCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sce assertion failed");
`else
`define SCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/sce_pkg.sv -----
// shared types, constants and reply tables of the capture engine
package sce_pkg;

    localparam int DEF_BUFFER_BYTES = 4096;
    localparam int DEF_CLOCK_SCALE  = 12;
    localparam int SYSTEM_MHZ       = 48;
    localparam int PROBE_COUNT      = 8;
    localparam int RESET_RUN_LIMIT  = 5;
    localparam int ID_LEN           = 4;
    localparam int META_LEN         = 27;
    localparam int QUEUE_DEPTH      = 4;

    // host command bytes
    localparam logic [7:0] OPC_RESET      = 8'h00;
    localparam logic [7:0] OPC_ARM        = 8'h01;
    localparam logic [7:0] OPC_ID         = 8'h02;
    localparam logic [7:0] OPC_META       = 8'h04;
    localparam logic [7:0] OPC_DIVIDER    = 8'h80;
    localparam logic [7:0] OPC_LENGTH     = 8'h81;
    localparam logic [7:0] OPC_TRIG_MASK  = 8'hC0;
    localparam logic [7:0] OPC_TRIG_VALUE = 8'hC1;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_WAIT    = 4'b0010,
        MODE_CAPTURE = 4'b0100,
        MODE_DONE    = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        JOB_ID      = 2'd0,
        JOB_META    = 2'd1,
        JOB_CAPTURE = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        logic      last;
    } job_ctrl_t;

    function automatic logic [7:0] id_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h31;
            2'd1:    b = 8'h41;
            2'd2:    b = 8'h4C;
            default: b = 8'h53;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] meta_byte(input logic [4:0] idx,
                                             input logic [31:0] buf_bytes,
                                             input logic [31:0] rate);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h01;
            5'd1:    b = 8'h4D;
            5'd2:    b = 8'h43;
            5'd3:    b = 8'h48;
            5'd4:    b = 8'h43;
            5'd5:    b = 8'h4B;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h02;
            5'd8:    b = 8'h30;
            5'd9:    b = 8'h2E;
            5'd10:   b = 8'h31;
            5'd11:   b = 8'h00;
            5'd12:   b = 8'h21;
            5'd13:   b = buf_bytes[31:24];
            5'd14:   b = buf_bytes[23:16];
            5'd15:   b = buf_bytes[15:8];
            5'd16:   b = buf_bytes[7:0];
            5'd17:   b = 8'h23;
            5'd18:   b = rate[31:24];
            5'd19:   b = rate[23:16];
            5'd20:   b = rate[15:8];
            5'd21:   b = rate[7:0];
            5'd22:   b = 8'h40;
            5'd23:   b = 8'(PROBE_COUNT);
            5'd24:   b = 8'h41;
            5'd25:   b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/sce_if.sv -----
// valid/ready channel interfaces for commands and reply bytes
interface sce_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  opcode;
    logic [31:0] argument;
    logic [7:0]  probe_byte;

    modport source (output valid, output operation, output opcode, output argument,
                    output probe_byte, input ready);
    modport sink (input valid, input operation, input opcode, input argument,
                  input probe_byte, output ready);
endinterface

interface sce_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       from_capture;

    modport source (output valid, output out_byte, output last_of_run,
                    output from_capture, input ready);
    modport sink (input valid, input out_byte, input last_of_run,
                  input from_capture, output ready);
endinterface

// ----- sv/sce_job_fifo.sv -----
// short job queue between the command front and the reply back
`include "sump_command_capture_engine_defines.svh"
module sce_job_fifo
    import sce_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SCE_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
    `SCE_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

// ----- sv/sce_front.sv -----
// command front: accepts items, decodes commands, runs capture control
`include "sump_command_capture_engine_defines.svh"
module sce_front
    import sce_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int CLOCK_SCALE  = DEF_CLOCK_SCALE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sce_cmd_if.sink                         cmd,
    input  logic                            job_room,
    input  logic                            queue_empty,
    output logic                            job_push,
    output job_ctrl_t                       job_ctrl,
    output logic [$clog2(BUFFER_BYTES)-1:0] job_addr,
    output logic                            wr_en,
    output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    output logic [7:0]                      wr_data
);

    localparam int ADDR_W    = $clog2(BUFFER_BYTES);
    localparam int POS_W     = $clog2(BUFFER_BYTES + 1);
    localparam int PERIOD_W  = 16 + $clog2(CLOCK_SCALE + 1);
    localparam int DEN_RAW   = SYSTEM_MHZ * 100 / CLOCK_SCALE;
    localparam int DEN       = (DEN_RAW == 0) ? 1 : DEN_RAW;
    localparam int DEN_W     = $clog2(DEN + 1);
    localparam int X_W       = 25;
    localparam int DIV_SHIFT = 25;
    localparam int RECIP_W   = 26;
    localparam int RECIP     = (1 << DIV_SHIFT) / DEN;

    mode_t                mode_reg, mode_next;
    logic [2:0]           reset_run_reg, reset_run_next;
    logic [7:0]           trig_mask_reg, trig_mask_next;
    logic [7:0]           trig_value_reg, trig_value_next;
    logic [15:0]          rate_div_reg, rate_div_next;
    logic [POS_W-1:0]     cap_len_reg, cap_len_next;
    logic [POS_W-1:0]     wp_reg, wp_next;
    logic [POS_W-1:0]     rp_reg, rp_next;
    logic [PERIOD_W-1:0]  tick_reg, tick_next;
    logic                 div_pend_reg, div_pend_next;
    logic [X_W-1:0]       div_x_reg, div_x_next;
    logic [X_W-1:0]       div_q0_reg, div_q0_next;

    op_t                  op;
    logic                 accept;
    logic                 is_arm;
    logic                 is_reply;
    logic                 drain_hit;
    logic                 trig_hit;
    logic [X_W-1:0]       div_x;
    logic [X_W+RECIP_W-1:0] div_prod;
    logic [X_W+DEN_W-1:0] div_back;
    logic [X_W-1:0]       div_rem;
    logic [X_W-1:0]       div_q;
    logic [16:0]          len_plus;
    logic [18:0]          len_bytes;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W-1:0]  tick_inc;
    logic [POS_W-1:0]     wp_new;

    assign op        = op_t'(cmd.operation);
    assign is_arm    = (op == OP_CMD) && (cmd.opcode == OPC_ARM);
    assign is_reply  = (op == OP_CMD) && ((cmd.opcode == OPC_ID) || (cmd.opcode == OPC_META));
    assign drain_hit = (op == OP_DRAIN) && (mode_reg == MODE_DONE) && (rp_reg < wp_reg);
    assign trig_hit  = |((~(cmd.probe_byte ^ trig_value_reg)) & trig_mask_reg);

    // arm waits for queued dumps so their entries are read before any rewrite
    assign cmd.ready = !div_pend_reg
                     && (!(is_reply || drain_hit) || job_room)
                     && (!is_arm || queue_empty);
    assign accept    = cmd.valid && cmd.ready;

    // divider by reciprocal: first estimate, then one correction step
    assign div_x    = {1'b0, cmd.argument[23:0]} + X_W'(1);
    assign div_prod = {{RECIP_W{1'b0}}, div_x} * {{X_W{1'b0}}, RECIP_W'(RECIP)};
    assign div_back = {{DEN_W{1'b0}}, div_q0_reg} * {{X_W{1'b0}}, DEN_W'(DEN)};
    assign div_rem  = div_x_reg - div_back[X_W-1:0];
    assign div_q    = div_q0_reg + ((div_rem >= X_W'(DEN)) ? X_W'(1) : X_W'(0));

    assign len_plus  = {1'b0, cmd.argument[15:0]} + 17'd1;
    assign len_bytes = {len_plus, 2'b00};

    assign period   = PERIOD_W'(rate_div_reg) * PERIOD_W'(CLOCK_SCALE);
    assign tick_inc = tick_reg + PERIOD_W'(1);

    assign wr_addr  = wp_reg[ADDR_W-1:0];
    assign wr_data  = cmd.probe_byte;
    assign job_addr = rp_reg[ADDR_W-1:0];

    always_comb
    begin
        mode_next       = mode_reg;
        reset_run_next  = reset_run_reg;
        trig_mask_next  = trig_mask_reg;
        trig_value_next = trig_value_reg;
        rate_div_next   = rate_div_reg;
        cap_len_next    = cap_len_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        tick_next       = tick_reg;
        div_pend_next   = 1'b0;
        div_x_next      = div_x_reg;
        div_q0_next     = div_q0_reg;
        wp_new          = wp_reg;
        wr_en           = 1'b0;
        job_push        = 1'b0;
        job_ctrl.kind   = JOB_CAPTURE;
        job_ctrl.last   = 1'b0;

        if (div_pend_reg)
        begin
            if (div_q > X_W'(16'hFFFF))
            begin
                rate_div_next = 16'hFFFF;
            end
            else if (div_q == '0)
            begin
                rate_div_next = 16'd1;
            end
            else
            begin
                rate_div_next = div_q[15:0];
            end
        end

        if (accept)
        begin
            case (op)
                OP_CMD:
                begin
                    if (cmd.opcode == OPC_RESET)
                    begin
                        if (reset_run_reg == 3'(RESET_RUN_LIMIT - 1))
                        begin
                            mode_next       = MODE_IDLE;
                            reset_run_next  = '0;
                            trig_mask_next  = '0;
                            trig_value_next = '0;
                            rate_div_next   = 16'd1;
                            cap_len_next    = POS_W'(BUFFER_BYTES);
                            wp_next         = '0;
                            rp_next         = '0;
                            tick_next       = '0;
                        end
                        else
                        begin
                            reset_run_next = reset_run_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        reset_run_next = '0;
                        case (cmd.opcode)
                            OPC_ARM:
                            begin
                                if (trig_mask_reg != '0)
                                begin
                                    mode_next = MODE_WAIT;
                                end
                                else
                                begin
                                    mode_next = MODE_CAPTURE;
                                    wp_next   = '0;
                                    rp_next   = '0;
                                    tick_next = '0;
                                end
                            end
                            OPC_ID:
                            begin
                                job_push      = 1'b1;
                                job_ctrl.kind = JOB_ID;
                            end
                            OPC_META:
                            begin
                                job_push      = 1'b1;
                                job_ctrl.kind = JOB_META;
                            end
                            OPC_TRIG_MASK:  trig_mask_next  = cmd.argument[7:0];
                            OPC_TRIG_VALUE: trig_value_next = cmd.argument[7:0];
                            OPC_DIVIDER:
                            begin
                                div_pend_next = 1'b1;
                                div_x_next    = div_x;
                                div_q0_next   = div_prod[DIV_SHIFT +: X_W];
                            end
                            OPC_LENGTH:
                            begin
                                if (len_bytes > 19'(BUFFER_BYTES))
                                begin
                                    cap_len_next = POS_W'(BUFFER_BYTES);
                                end
                                else
                                begin
                                    cap_len_next = POS_W'(len_bytes);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                OP_TICK:
                begin
                    if (mode_reg == MODE_WAIT)
                    begin
                        if (trig_hit)
                        begin
                            mode_next = MODE_CAPTURE;
                            wp_next   = '0;
                            rp_next   = '0;
                            tick_next = '0;
                        end
                    end
                    else if (mode_reg == MODE_CAPTURE)
                    begin
                        if ((wp_reg < cap_len_reg) && (tick_reg == '0))
                        begin
                            wr_en  = 1'b1;
                            wp_new = wp_reg + POS_W'(1);
                        end
                        wp_next   = wp_new;
                        tick_next = (tick_inc >= period) ? '0 : tick_inc;
                        if (wp_new >= cap_len_reg)
                        begin
                            mode_next = MODE_DONE;
                            rp_next   = '0;
                        end
                    end
                end
                OP_DRAIN:
                begin
                    if (drain_hit)
                    begin
                        job_push      = 1'b1;
                        job_ctrl.kind = JOB_CAPTURE;
                        job_ctrl.last = ((rp_reg + POS_W'(1)) == wp_reg);
                        rp_next       = rp_reg + POS_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            reset_run_reg  <= '0;
            trig_mask_reg  <= '0;
            trig_value_reg <= '0;
            rate_div_reg   <= 16'd1;
            cap_len_reg    <= POS_W'(BUFFER_BYTES);
            wp_reg         <= '0;
            rp_reg         <= '0;
            tick_reg       <= '0;
            div_pend_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            reset_run_reg  <= reset_run_next;
            trig_mask_reg  <= trig_mask_next;
            trig_value_reg <= trig_value_next;
            rate_div_reg   <= rate_div_next;
            cap_len_reg    <= cap_len_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            tick_reg       <= tick_next;
            div_pend_reg   <= div_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_x_reg  <= div_x_next;
        div_q0_reg <= div_q0_next;
    end

    `SCE_ASSERT_IMP(a_drain_in_range, clk, rst_n, mode_reg == MODE_DONE, rp_reg <= wp_reg)
    `SCE_ASSERT_NXT(a_div_one_cycle, clk, rst_n, div_pend_reg, !div_pend_reg)

endmodule

// ----- sv/sce_back.sv -----
// reply back: expands jobs into bytes, holds the sample store
`include "sump_command_capture_engine_defines.svh"
module sce_back
    import sce_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int CLOCK_SCALE  = DEF_CLOCK_SCALE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  job_ctrl_t                       head_ctrl,
    input  logic [$clog2(BUFFER_BYTES)-1:0] head_addr,
    output logic                            head_pop,
    input  logic                            wr_en,
    input  logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    sce_rsp_if.source                       rsp
);

    localparam int SAMPLE_RATE = SYSTEM_MHZ * 1000000 / CLOCK_SCALE;

    logic [7:0]  store_mem [BUFFER_BYTES];
    logic [7:0]  rd_data_reg;

    logic [4:0]  beat_reg, beat_next;
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_cap_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_cap_reg;

    logic        out_load;
    logic        beat_go;
    logic        rd_en;
    logic [7:0]  beat_byte;
    logic        beat_last;
    logic        beat_final;

    assign out_load = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign beat_go  = head_valid && (!s1_valid_reg || out_load);
    assign rd_en    = beat_go && (head_ctrl.kind == JOB_CAPTURE);
    assign head_pop = beat_go && beat_final;

    always_comb
    begin
        beat_byte  = 8'h00;
        beat_last  = 1'b0;
        beat_final = 1'b1;
        case (head_ctrl.kind)
            JOB_ID:
            begin
                beat_byte  = id_byte(beat_reg[1:0]);
                beat_last  = (beat_reg == 5'(ID_LEN - 1));
                beat_final = beat_last;
            end
            JOB_META:
            begin
                beat_byte  = meta_byte(beat_reg, 32'(BUFFER_BYTES), 32'(SAMPLE_RATE));
                beat_last  = (beat_reg == 5'(META_LEN - 1));
                beat_final = beat_last;
            end
            JOB_CAPTURE:
            begin
                beat_last = head_ctrl.last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        beat_next      = beat_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (beat_go)
        begin
            beat_next = beat_final ? '0 : beat_reg + 5'd1;
        end
        if (beat_go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_go)
        begin
            s1_byte_reg <= beat_byte;
            s1_last_reg <= beat_last;
            s1_cap_reg  <= (head_ctrl.kind == JOB_CAPTURE);
        end
        if (out_load)
        begin
            out_byte_reg <= s1_cap_reg ? rd_data_reg : s1_byte_reg;
            out_last_reg <= s1_last_reg;
            out_cap_reg  <= s1_cap_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_byte     = out_byte_reg;
    assign rsp.last_of_run  = out_last_reg;
    assign rsp.from_capture = out_cap_reg;

    `SCE_ASSERT_IMP(a_beat_range, clk, rst_n, 1'b1, beat_reg < 5'(META_LEN))

endmodule

// ----- sv/sump_command_capture_engine.sv -----
// top level of the logic-analyzer command and capture engine
// path: a reply byte passes the job queue, the beat register and the output register
// throughput: one item per cycle; a divider command holds the next item while it finishes,
//   arm waits for an empty job queue, id, metadata and drain items wait on a full queue
// output: one byte per cycle unless rsp.ready stalls; metadata 27 bytes, id 4, a sample 1
// reset: asynchronous, active low; control returns to defaults, store contents stay
module sump_command_capture_engine
    import sce_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int CLOCK_SCALE  = DEF_CLOCK_SCALE
) (
    input  logic      clk,
    input  logic      rst_n,
    sce_cmd_if.sink   cmd,
    sce_rsp_if.source rsp
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CTRL_W = $bits(job_ctrl_t);
    localparam int JOB_W  = ADDR_W + CTRL_W;

    // front to queue
    logic              job_push;
    job_ctrl_t         job_ctrl;
    logic [ADDR_W-1:0] job_addr;

    // queue to back
    logic [JOB_W-1:0]  head;
    logic              head_pop;
    logic              q_full;
    logic              q_empty;
    job_ctrl_t         head_ctrl;
    logic [ADDR_W-1:0] head_addr;

    // capture writes go straight to the store in the back
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    assign head_ctrl = job_ctrl_t'(head[CTRL_W-1:0]);
    assign head_addr = head[JOB_W-1:CTRL_W];

    // front: decode, trigger, divider, capture counters
    sce_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CLOCK_SCALE  (CLOCK_SCALE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .job_room    (!q_full),
        .queue_empty (q_empty),
        .job_push    (job_push),
        .job_ctrl    (job_ctrl),
        .job_addr    (job_addr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    // jobs waiting for the reply side: id, metadata or one captured byte
    sce_job_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({job_addr, job_ctrl}),
        .pop       (head_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: byte sequencing, store read and output register
    sce_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CLOCK_SCALE  (CLOCK_SCALE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head_ctrl  (head_ctrl),
        .head_addr  (head_addr),
        .head_pop   (head_pop),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rsp        (rsp)
    );

endmodule

// ----- tb/tb_sump_command_capture_engine.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the logic-analyzer command and capture engine
module tb_sump_command_capture_engine;
    import sce_pkg::*;

    // sizes of the block as built with its default parameters
    localparam int CAPTURE_DEPTH = DEF_BUFFER_BYTES;
    localparam int TICKS_PER_DIV = DEF_CLOCK_SCALE;
    localparam int DIV_DENOM     = SYSTEM_MHZ * 100 / DEF_CLOCK_SCALE;
    localparam int SAMPLE_RATE   = SYSTEM_MHZ * 1000000 / DEF_CLOCK_SCALE;

    // run shape
    localparam int RANDOM_ITEMS  = 350;
    localparam int IDLE_PERCENT  = 27;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int STEADY_FROM   = 100;
    localparam int STEADY_UNTIL  = 300;

    // metadata reply tokens
    localparam logic [7:0] META_END             = 8'h00;
    localparam logic [7:0] META_KEY_NAME        = 8'h01;
    localparam logic [7:0] META_KEY_FIRMWARE    = 8'h02;
    localparam logic [7:0] META_KEY_SAMPLE_MEM  = 8'h21;
    localparam logic [7:0] META_KEY_SAMPLE_RATE = 8'h23;
    localparam logic [7:0] META_KEY_PROBES      = 8'h40;
    localparam logic [7:0] META_KEY_PROTOCOL    = 8'h41;
    localparam logic [7:0] META_PROTO_REV       = 8'h02;

    localparam logic [7:0] ID_CHARS   [ID_LEN] = '{8'h31, 8'h41, 8'h4C, 8'h53};
    localparam logic [7:0] NAME_CHARS [5]      = '{8'h4D, 8'h43, 8'h48, 8'h43, 8'h4B};
    localparam logic [7:0] FW_CHARS   [3]      = '{8'h30, 8'h2E, 8'h31};

    typedef struct {
        op_t         operation;
        logic [7:0]  opcode;
        logic [31:0] argument;
        logic [7:0]  probe_byte;
    } host_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       sample;
    } reply_t;

    logic clk;
    logic rst_n;

    sce_cmd_if cmd();
    sce_rsp_if rsp();

    sump_command_capture_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // stimulus waiting to be offered and reply bytes waiting to be seen
    host_item_t host_items[$];
    reply_t     predicted_bytes[$];

    // shadow of the engine state, advanced once per accepted item
    mode_t       cur_mode;
    int          zero_cmd_run;
    logic [7:0]  mask_bits;
    logic [7:0]  match_bits;
    logic [15:0] clk_div;
    logic [12:0] cap_len;
    logic [7:0]  sample_mem [CAPTURE_DEPTH];
    logic [12:0] fill_ptr;
    logic [12:0] dump_ptr;
    logic [19:0] div_count;

    // bookkeeping
    int random_count;
    int cycle_count;
    int quiet_cycles;
    int mismatch_count;
    int cmd_count;
    int ticks_sent;
    int drain_count;
    int reply_count;
    int sample_count;
    logic steady_window;

    // no idling on either side inside this window of cycles
    assign steady_window = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_UNTIL);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    task automatic restore_defaults();
        cur_mode     = MODE_IDLE;
        zero_cmd_run = 0;
        mask_bits    = 8'h00;
        match_bits   = 8'h00;
        clk_div      = 16'd1;
        cap_len      = 13'(CAPTURE_DEPTH);
        fill_ptr     = '0;
        dump_ptr     = '0;
        div_count    = '0;
    endtask

    task automatic begin_capture();
        cur_mode  = MODE_CAPTURE;
        fill_ptr  = '0;
        dump_ptr  = '0;
        div_count = '0;
    endtask

    task automatic add_reply(input logic [7:0] data, input logic last, input logic sample);
        reply_t r;
        r.data   = data;
        r.last   = last;
        r.sample = sample;
        predicted_bytes.push_back(r);
    endtask

    // byte k of the metadata reply, big-endian words for memory size and rate
    function automatic logic [7:0] meta_reply(input int k);
        logic [31:0] depth_word;
        logic [31:0] rate_word;
        depth_word = CAPTURE_DEPTH;
        rate_word  = SAMPLE_RATE;
        if (k == 0) return META_KEY_NAME;
        if (k < 6) return NAME_CHARS[k - 1];
        if (k == 6) return META_END;
        if (k == 7) return META_KEY_FIRMWARE;
        if (k < 11) return FW_CHARS[k - 8];
        if (k == 11) return META_END;
        if (k == 12) return META_KEY_SAMPLE_MEM;
        if (k < 17) return depth_word[8 * (16 - k) +: 8];
        if (k == 17) return META_KEY_SAMPLE_RATE;
        if (k < 22) return rate_word[8 * (21 - k) +: 8];
        if (k == 22) return META_KEY_PROBES;
        if (k == 23) return 8'(PROBE_COUNT);
        if (k == 24) return META_KEY_PROTOCOL;
        if (k == 25) return META_PROTO_REV;
        return META_END;
    endfunction

    // advance the shadow state by one accepted item and queue its reply bytes
    task automatic predict_replies(input logic [1:0] op_bits, input logic [7:0] opc,
                                   input logic [31:0] arg, input logic [7:0] probe);
        int k;
        int quot;
        int len;
        int period;
        case (op_t'(op_bits))
            OP_CMD:
            begin
                cmd_count++;
                if (opc == OPC_RESET)
                begin
                    // only a fifth reset command in a row takes effect
                    zero_cmd_run++;
                    if (zero_cmd_run >= RESET_RUN_LIMIT) restore_defaults();
                end
                else
                begin
                    zero_cmd_run = 0;
                    case (opc)
                        OPC_ARM:
                        begin
                            if (mask_bits != 8'h00) cur_mode = MODE_WAIT;
                            else begin_capture();
                        end
                        OPC_ID:
                            for (k = 0; k < ID_LEN; k++)
                                add_reply(ID_CHARS[k], k == ID_LEN - 1, 1'b0);
                        OPC_META:
                            for (k = 0; k < META_LEN; k++)
                                add_reply(meta_reply(k), k == META_LEN - 1, 1'b0);
                        OPC_TRIG_MASK:  mask_bits  = arg[7:0];
                        OPC_TRIG_VALUE: match_bits = arg[7:0];
                        OPC_DIVIDER:
                        begin
                            quot = (int'(arg[23:0]) + 1) / DIV_DENOM;
                            if (quot > 16'hFFFF) quot = 16'hFFFF;
                            if (quot == 0) quot = 1;
                            clk_div = 16'(quot);
                        end
                        OPC_LENGTH:
                        begin
                            len = (int'(arg[15:0]) + 1) * 4;
                            if (len > CAPTURE_DEPTH) len = CAPTURE_DEPTH;
                            cap_len = 13'(len);
                        end
                        default: ;
                    endcase
                end
            end
            OP_TICK:
            begin
                ticks_sent++;
                if (cur_mode == MODE_WAIT)
                begin
                    // any masked probe equal to its trigger bit starts capture;
                    // the triggering tick stores nothing
                    if (((~(probe ^ match_bits)) & mask_bits) != 8'h00) begin_capture();
                end
                else if (cur_mode == MODE_CAPTURE)
                begin
                    period = int'(clk_div) * TICKS_PER_DIV;
                    if (fill_ptr < cap_len && div_count == 0)
                    begin
                        if (fill_ptr < CAPTURE_DEPTH) sample_mem[fill_ptr] = probe;
                        fill_ptr++;
                    end
                    div_count++;
                    if (int'(div_count) >= period) div_count = '0;
                    // a length lowered during capture also ends it here
                    if (fill_ptr >= cap_len)
                    begin
                        cur_mode = MODE_DONE;
                        dump_ptr = '0;
                    end
                end
            end
            OP_DRAIN:
            begin
                drain_count++;
                if (cur_mode == MODE_DONE && dump_ptr < fill_ptr && dump_ptr < CAPTURE_DEPTH)
                begin
                    k = int'(dump_ptr);
                    dump_ptr++;
                    add_reply(sample_mem[k], dump_ptr == fill_ptr, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic queue_item(input op_t op, input logic [7:0] opc,
                              input logic [31:0] arg, input logic [7:0] probe);
        host_item_t it;
        it.operation  = op;
        it.opcode     = opc;
        it.argument   = arg;
        it.probe_byte = probe;
        host_items.push_back(it);
        if (op != OP_NONE) random_count++;
    endtask

    // unused fields carry random junk so that every bit toggles
    task automatic send_cmd(input logic [7:0] opc, input logic [31:0] arg);
        queue_item(OP_CMD, opc, arg, 8'($urandom));
    endtask

    task automatic send_tick(input logic [7:0] probe);
        queue_item(OP_TICK, 8'($urandom), $urandom, probe);
    endtask

    task automatic send_drain();
        queue_item(OP_DRAIN, 8'($urandom), $urandom, 8'($urandom));
    endtask

    function automatic logic [7:0] unknown_opcode();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == OPC_RESET || c == OPC_ARM || c == OPC_ID || c == OPC_META ||
               c == OPC_DIVIDER || c == OPC_LENGTH || c == OPC_TRIG_MASK ||
               c == OPC_TRIG_VALUE);
        return c;
    endfunction

    // stray traffic that must not disturb a capture in progress
    task automatic send_noise();
        int n;
        case ($urandom_range(0, 6))
            0: queue_item(OP_NONE, 8'($urandom), $urandom, 8'($urandom));
            1: send_drain();
            2: send_cmd(unknown_opcode(), $urandom);
            3: send_cmd(OPC_ID, $urandom);
            4: send_cmd(OPC_META, $urandom);
            default:
            begin
                // a reset run that is cut short before it takes effect
                n = $urandom_range(1, RESET_RUN_LIMIT - 1);
                repeat (n) send_cmd(OPC_RESET, $urandom);
                send_cmd(unknown_opcode(), $urandom);
            end
        endcase
    endtask

    task automatic send_trigger(input logic [7:0] mask, input logic [7:0] value);
        if (mask != 8'h00)
        begin
            repeat ($urandom_range(0, 4)) send_tick(8'($urandom));
            send_tick(value);
        end
    endtask

    // one setup, arm, capture and dump sequence; len_arg and div_arg are the
    // low fields of the length and divider arguments
    task automatic capture_session(input logic [15:0] len_arg, input logic [23:0] div_arg,
                                   input bit clean);
        logic [7:0]  mask;
        logic [7:0]  value;
        logic [7:0]  setup_opc [4];
        logic [31:0] setup_arg [4];
        logic [7:0]  t_opc;
        logic [31:0] t_arg;
        int i;
        int j;
        int flavor;
        int len;
        int div;
        int ticks;
        int lower_at;
        int drains;

        mask  = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        value = 8'($urandom);
        setup_opc[0] = OPC_TRIG_MASK;  setup_arg[0] = {24'($urandom), mask};
        setup_opc[1] = OPC_TRIG_VALUE; setup_arg[1] = {24'($urandom), value};
        setup_opc[2] = OPC_DIVIDER;    setup_arg[2] = {8'($urandom), div_arg};
        setup_opc[3] = OPC_LENGTH;     setup_arg[3] = {16'($urandom), len_arg};
        for (i = 3; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t_opc = setup_opc[i]; setup_opc[i] = setup_opc[j]; setup_opc[j] = t_opc;
            t_arg = setup_arg[i]; setup_arg[i] = setup_arg[j]; setup_arg[j] = t_arg;
        end
        for (i = 0; i < 4; i++)
        begin
            if (!clean && $urandom_range(0, 99) < 20) send_noise();
            send_cmd(setup_opc[i], setup_arg[i]);
        end

        send_cmd(OPC_ARM, $urandom);
        flavor = clean ? 99 : $urandom_range(0, 99);
        if (flavor < 8)
        begin
            // a full reset run aborts the capture
            repeat ($urandom_range(0, 6)) send_tick(8'($urandom));
            repeat (RESET_RUN_LIMIT) send_cmd(OPC_RESET, $urandom);
            repeat ($urandom_range(1, 3)) send_drain();
            return;
        end
        if (flavor < 18)
        begin
            // rearm while waiting or capturing
            send_trigger(mask, value);
            repeat ($urandom_range(0, 6)) send_tick(8'($urandom));
            send_cmd(OPC_ARM, $urandom);
        end
        send_trigger(mask, value);

        len = (int'(len_arg) + 1) * 4;
        if (len > CAPTURE_DEPTH) len = CAPTURE_DEPTH;
        div = (int'(div_arg) + 1) / DIV_DENOM;
        if (div == 0) div = 1;
        ticks = (len - 1) * div * TICKS_PER_DIV + 1 + $urandom_range(0, 3);
        lower_at = (flavor >= 18 && flavor < 28) ? $urandom_range(0, ticks - 1) : -1;
        for (i = 0; i < ticks; i++)
        begin
            if (!clean && $urandom_range(0, 99) < 5) send_noise();
            // shortest length written while samples are still coming in
            if (i == lower_at) send_cmd(OPC_LENGTH, {16'($urandom), 16'h0000});
            send_tick(8'($urandom));
        end

        drains = len + $urandom_range(0, 2);
        for (i = 0; i < drains; i++)
        begin
            if (!clean && $urandom_range(0, 99) < 5) send_noise();
            if (flavor >= 28 && flavor < 33 && i == drains / 2) send_cmd(OPC_ARM, $urandom);
            send_drain();
        end
    endtask

    task automatic build_stimulus();
        logic [15:0] len_arg;
        logic [23:0] div_arg;
        int pick;

        // directed: ignored items, replies, cut reset run, field extremes,
        // trigger miss, then a full reset run back to defaults
        queue_item(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        send_tick(8'hFF);
        send_drain();
        send_cmd(OPC_ID, 32'hFFFF_FFFF);
        send_cmd(OPC_META, 32'h0000_0000);
        repeat (RESET_RUN_LIMIT - 1) send_cmd(OPC_RESET, 32'h0000_0000);
        send_cmd(8'hFF, 32'h0000_0000);
        send_cmd(OPC_TRIG_MASK, 32'hFFFF_FFFF);
        send_cmd(OPC_TRIG_VALUE, 32'h0000_00A5);
        send_cmd(OPC_DIVIDER, 32'hFFFF_FFFF);
        send_cmd(OPC_DIVIDER, 32'h0000_0000);
        send_cmd(OPC_LENGTH, 32'hFFFF_FFFF);
        send_cmd(OPC_LENGTH, 32'h0000_0000);
        send_cmd(OPC_ARM, 32'h0000_0000);
        send_tick(8'h5A);
        send_drain();
        repeat (RESET_RUN_LIMIT) send_cmd(OPC_RESET, 32'hFFFF_FFFF);
        send_cmd(OPC_ID, 32'h0000_0000);

        // random sessions, mostly short captures at the fastest divider
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60) len_arg = 16'd0;
            else if (pick < 85) len_arg = 16'd1;
            else len_arg = 16'($urandom_range(2, 3));
            if ($urandom_range(0, 99) < 85) div_arg = 24'($urandom_range(0, DIV_DENOM - 2));
            else div_arg = 24'($urandom_range(2 * DIV_DENOM - 1, 2 * DIV_DENOM + 100));
            capture_session(len_arg, div_arg, 1'b0);
            if ($urandom_range(0, 99) < 30) send_noise();
        end

        // one last short capture with no stray traffic around it
        capture_session(16'd1, 24'd0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, predicts each one on acceptance
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive_items
        host_item_t it;
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                predict_replies(cmd.operation, cmd.opcode, cmd.argument, cmd.probe_byte);
            // only move on once the current item is gone
            if (!cmd.valid || cmd.ready)
            begin
                if (host_items.size() != 0 &&
                    (steady_window || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    it = host_items.pop_front();
                    cmd.valid      <= 1'b1;
                    cmd.operation  <= it.operation;
                    cmd.opcode     <= it.opcode;
                    cmd.argument   <= it.argument;
                    cmd.probe_byte <= it.probe_byte;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, compares each reply byte in order
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                reply_count++;
                if (rsp.from_capture === 1'b1) sample_count++;
                if (predicted_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reply byte %h last %b capture %b",
                                              rsp.out_byte, rsp.last_of_run,
                                              rsp.from_capture));
                end
                else
                begin
                    want = predicted_bytes.pop_front();
                    if (rsp.out_byte !== want.data || rsp.last_of_run !== want.last ||
                        rsp.from_capture !== want.sample)
                        report_mismatch($sformatf(
                            "reply %0d: expected byte %h last %b capture %b, got %h %b %b",
                            reply_count, want.data, want.last, want.sample,
                            rsp.out_byte, rsp.last_of_run, rsp.from_capture));
                end
            end
            rsp.ready <= steady_window || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // cycle count and watchdog on cycles where nothing is handed over
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    initial
    begin : run_test
        bit timed_out;

        // every input known from time zero, reset held low
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.operation  = OP_NONE;
        cmd.opcode     = 8'h00;
        cmd.argument   = 32'h0000_0000;
        cmd.probe_byte = 8'h00;
        rsp.ready      = 1'b0;
        cycle_count    = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        cmd_count      = 0;
        ticks_sent     = 0;
        drain_count    = 0;
        reply_count    = 0;
        sample_count   = 0;

        restore_defaults();
        build_stimulus();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sample between edges so the loop sees settled handshake state
        while (quiet_cycles < QUIET_LIMIT &&
               (host_items.size() != 0 || cmd.valid || predicted_bytes.size() != 0))
            @(negedge clk);
        timed_out = (quiet_cycles >= QUIET_LIMIT);

        if (timed_out)
            $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
        else
            repeat (TAIL_CYCLES) @(negedge clk);

        if (predicted_bytes.size() != 0)
            report_mismatch($sformatf("%0d reply bytes never arrived", predicted_bytes.size()));

        $display("sent %0d commands, %0d probe ticks and %0d drain requests",
                 cmd_count, ticks_sent, drain_count);
        $display("checked %0d reply bytes, %0d of them captured samples",
                 reply_count, sample_count);
        if (!timed_out && mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
